### rtl/core/clw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_pkg
// Shared types and fixed-point constants of the cloud liquid water check.
// ----------------------------------------------------------------------------
package clw_pkg;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [15:0] T_MAX     = 16'd36352;
  localparam logic [15:0] T_REF     = 16'd36480;
  localparam logic [14:0] ANG_MAX   = 15'd23040;
  localparam logic [14:0] ANG_HALF  = 15'd11520;

  // angle to radians: a * PI / 23040 = a * COS_P + a * COS_R / 23040
  localparam logic [17:0] COS_P = 18'(PI_Q30 / 64'd23040);
  localparam logic [14:0] COS_R = 15'(PI_Q30 % 64'd23040);

  localparam int unsigned COS_DEN [8] = '{240, 182, 132, 90, 56, 30, 12, 2};

  localparam logic signed [31:0] K_754  = 32'((64'd754  << 24) / 64'd1000);
  localparam logic signed [31:0] K_2265 = 32'((64'd2265 << 24) / 64'd1000);
  localparam logic signed [31:0] K_8240 = 32'((64'd8240 << 24) / 64'd1000);
  localparam logic signed [31:0] K_2622 = 32'((64'd2622 << 24) / 64'd1000);
  localparam logic signed [31:0] K_1846 = 32'((64'd1846 << 24) / 64'd1000);

  localparam int unsigned COS_LAT = 22;
  localparam int unsigned LN_LAT  = 45;
  localparam int unsigned RET_LAT = 4;

  localparam logic [1:0] MODE_OBS = 2'd0;
  localparam logic [1:0] MODE_SIM = 2'd1;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_THR0,
    REG_THR1,
    REG_THR2,
    REG_THR3
  } clw_reg_e;

  typedef struct packed {
    logic ok_obs;
    logic ok_sim;
    logic apply;
  } clw_side_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [3:0][15:0] thr;
  } clw_cfg_t;

  typedef struct packed {
    logic [15:0] water_value;
    logic        water_absent;
    logic [15:0] obs_water;
    logic        obs_water_absent;
    logic [15:0] sim_water;
    logic        sim_water_absent;
    logic [3:0]  reject_mask;
  } clw_res_t;

  // Q24 product of magnitudes, truncated toward zero, then signed
  function automatic logic signed [31:0] smul24(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] pr;
    logic [31:0] m;
    ua = a[31] ? (~a + 32'd1) : a;
    ub = b[31] ? (~b + 32'd1) : b;
    pr = ua * ub;
    m  = pr[55:24];
    return (a[31] ^ b[31]) ? signed'(~m + 32'd1) : signed'(m);
  endfunction

endpackage

### rtl/core/clw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_if
// Request channels of the cloud liquid water check.
// ----------------------------------------------------------------------------
interface clw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] obs_temp_a;
  logic [15:0] obs_temp_b;
  logic [15:0] sim_temp_a;
  logic [15:0] sim_temp_b;
  logic [14:0] zenith_angle;
  logic [4:0]  absent_mask;
  logic        apply_check;

  modport source (output valid, obs_temp_a, obs_temp_b, sim_temp_a, sim_temp_b,
                  zenith_angle, absent_mask, apply_check, input ready);
  modport sink   (input valid, obs_temp_a, obs_temp_b, sim_temp_a, sim_temp_b,
                  zenith_angle, absent_mask, apply_check, output ready);
endinterface

interface clw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] water_value;
  logic        water_absent;
  logic [15:0] obs_water;
  logic        obs_water_absent;
  logic [15:0] sim_water;
  logic        sim_water_absent;
  logic [3:0]  reject_mask;

  modport source (output valid, water_value, water_absent, obs_water,
                  obs_water_absent, sim_water, sim_water_absent, reject_mask,
                  input ready);
  modport sink   (input valid, water_value, water_absent, obs_water,
                  obs_water_absent, sim_water, sim_water_absent, reject_mask,
                  output ready);
endinterface

### rtl/core/cloud_liquid_water_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cloud_liquid_water_check
// Two-channel microwave cloud liquid water retrieval and reject check.
//
// One request on in_i carries one observation location; one request on out_o
// returns its observed, simulated and selected CLW and the reject mask.
// A shared cosine unit and four log lanes (observed and simulated pairs)
// feed two retrieval lanes; a merge stage selects by mode and flags channels.
// A location passes through the log lanes (29-step radix-2 divider plus
// 13-term series) and then the retrieval lane before output valid.
// Throughput: one location per cycle while out_o is not stalled.
// Reset clears the pipeline valid bits, the output valid and all registers
// of the APB port (mode and thresholds read 0).
// When the receiver stalls with a result waiting, the pipeline keeps
// advancing until a finished location reaches its last stage; then it holds
// and in_i.ready drops until out_o is taken.
// Registers: 0 retrieval_mode, 1..4 threshold_ch0..3, at byte address 4*i.
// ----------------------------------------------------------------------------
module cloud_liquid_water_check import clw_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clw_in_if.sink      in_i,
  clw_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DEPTH = LN_LAT + RET_LAT;
  localparam int unsigned CDLY  = LN_LAT - COS_LAT;

  clw_cfg_t cfg_q;

  logic             adv;
  logic [DEPTH-1:0] vld_q;
  logic             out_vq;
  clw_side_t        side_d;
  clw_side_t        side_q [DEPTH];

  logic signed [25:0] cos_w;
  logic signed [25:0] cd_q [CDLY];
  logic [27:0]        ln_oa, ln_ob, ln_sa, ln_sb;
  logic [15:0]        obs_w, sim_w;
  clw_res_t           res;

  // APB
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (clw_reg_e'(paddr[4:2]))
        REG_MODE: cfg_q.mode   <= pwdata[1:0];
        REG_THR0: cfg_q.thr[0] <= pwdata[15:0];
        REG_THR1: cfg_q.thr[1] <= pwdata[15:0];
        REG_THR2: cfg_q.thr[2] <= pwdata[15:0];
        REG_THR3: cfg_q.thr[3] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (clw_reg_e'(paddr[4:2]))
      REG_MODE: prdata = {30'd0, cfg_q.mode};
      REG_THR0: prdata = {16'd0, cfg_q.thr[0]};
      REG_THR1: prdata = {16'd0, cfg_q.thr[1]};
      REG_THR2: prdata = {16'd0, cfg_q.thr[2]};
      REG_THR3: prdata = {16'd0, cfg_q.thr[3]};
      default:  prdata = 32'd0;
    endcase
  end

  // flow control
  assign adv        = !(vld_q[DEPTH-1] && out_vq && !out_o.ready);
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      out_vq <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[DEPTH-2:0], in_i.valid};
      end
      if (adv && vld_q[DEPTH-1]) begin
        out_vq <= 1'b1;
      end else if (out_o.ready) begin
        out_vq <= 1'b0;
      end
    end
  end

  // missing decision at entry
  always_comb begin
    side_d.ok_obs = !(in_i.absent_mask[0] || in_i.absent_mask[1] || in_i.absent_mask[4])
                    && (in_i.obs_temp_a != 16'd0) && (in_i.obs_temp_b != 16'd0)
                    && (in_i.obs_temp_a <= T_MAX) && (in_i.obs_temp_b <= T_MAX);
    side_d.ok_sim = !(in_i.absent_mask[2] || in_i.absent_mask[3] || in_i.absent_mask[4])
                    && (in_i.sim_temp_a != 16'd0) && (in_i.sim_temp_b != 16'd0)
                    && (in_i.sim_temp_a <= T_MAX) && (in_i.sim_temp_b <= T_MAX);
    side_d.apply  = in_i.apply_check;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DEPTH; i++) begin
        side_q[i] <= side_q[i-1];
      end
      cd_q[0] <= cos_w;
      for (int i = 1; i < CDLY; i++) begin
        cd_q[i] <= cd_q[i-1];
      end
    end
  end

  clw_cos u_cos (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (in_i.zenith_angle),
    .cos_o   (cos_w)
  );

  clw_ln u_ln_oa (.clk_i(clk_i), .en_i(adv), .temp_i(in_i.obs_temp_a), .ln_o(ln_oa));
  clw_ln u_ln_ob (.clk_i(clk_i), .en_i(adv), .temp_i(in_i.obs_temp_b), .ln_o(ln_ob));
  clw_ln u_ln_sa (.clk_i(clk_i), .en_i(adv), .temp_i(in_i.sim_temp_a), .ln_o(ln_sa));
  clw_ln u_ln_sb (.clk_i(clk_i), .en_i(adv), .temp_i(in_i.sim_temp_b), .ln_o(ln_sb));

  clw_ret u_ret_obs (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cos_i   (cd_q[CDLY-1]),
    .ln_a_i  (ln_oa),
    .ln_b_i  (ln_ob),
    .water_o (obs_w)
  );

  clw_ret u_ret_sim (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cos_i   (cd_q[CDLY-1]),
    .ln_a_i  (ln_sa),
    .ln_b_i  (ln_sb),
    .water_o (sim_w)
  );

  clw_merge #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_merge (
    .clk_i  (clk_i),
    .load_i (adv && vld_q[DEPTH-1]),
    .obs_i  (obs_w),
    .sim_i  (sim_w),
    .side_i (side_q[DEPTH-1]),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_o.valid            = out_vq;
  assign out_o.water_value      = res.water_value;
  assign out_o.water_absent     = res.water_absent;
  assign out_o.obs_water        = res.obs_water;
  assign out_o.obs_water_absent = res.obs_water_absent;
  assign out_o.sim_water        = res.sim_water;
  assign out_o.sim_water_absent = res.sim_water_absent;
  assign out_o.reject_mask      = res.reject_mask;

endmodule

### rtl/core/clw_cos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_cos
// Pipelined cosine of the zenith angle, Q24 signed, Horner series.
// ----------------------------------------------------------------------------
module clw_cos import clw_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [14:0]        angle_i,
  output logic signed [25:0] cos_o
);

  localparam logic [19:0] M45 = 20'(((64'd1 << 25) + 64'd44) / 64'd45);

  logic [14:0] a_cl;
  logic [13:0] a_d;
  logic        neg_d;

  logic [13:0] a_q;
  logic        neg0_q, neg1_q, neg2_q, neg3_q, neg4_q;
  logic [30:0] ap_q, ap2_q;
  logic [27:0] ar_q;
  logic [38:0] qm45_q;
  logic [30:0] theta_q;
  logic [61:0] sq_q;

  logic [31:0] u_q   [8];
  logic [64:0] qm_q  [8];
  logic [31:0] x2a_q [8];
  logic [31:0] x2b_q [8];
  logic        nega_q[8];
  logic        negb_q[8];
  logic [62:0] hp    [8];
  logic [30:0] y_in  [8];
  logic [30:0] y_out [8];
  logic [31:0] x2_in [8];
  logic        neg_in[8];

  logic signed [25:0] c_q;

  always_comb begin
    a_cl  = (angle_i > ANG_MAX) ? ANG_MAX : angle_i;
    neg_d = a_cl > ANG_HALF;
    a_d   = neg_d ? 14'(ANG_MAX - a_cl) : 14'(a_cl);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= a_d;
      neg0_q  <= neg_d;
      ap_q    <= 31'(a_q * COS_P);
      ar_q    <= 28'(a_q * COS_R);
      neg1_q  <= neg0_q;
      ap2_q   <= ap_q;
      qm45_q  <= 39'(ar_q[27:9] * M45);
      neg2_q  <= neg1_q;
      theta_q <= ap2_q + 31'(qm45_q >> 25);
      neg3_q  <= neg2_q;
      sq_q    <= 62'(theta_q * theta_q);
      neg4_q  <= neg3_q;
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_step
    localparam int unsigned K  = COS_DEN[i];
    localparam int unsigned SH = 32 + $clog2(K);
    localparam logic [32:0] M  = 33'(((65'd1 << SH) + 65'(K) - 65'd1) / 65'(K));

    logic [30:0] t;

    if (i == 0) begin : g_first
      assign y_in[i]   = 31'h4000_0000;
      assign x2_in[i]  = sq_q[61:30];
      assign neg_in[i] = neg4_q;
    end else begin : g_next
      assign y_in[i]   = y_out[i-1];
      assign x2_in[i]  = x2b_q[i-1];
      assign neg_in[i] = negb_q[i-1];
    end

    assign hp[i]    = 63'(x2_in[i] * y_in[i]);
    assign t        = 31'(qm_q[i] >> SH);
    assign y_out[i] = (t >= 31'h4000_0000) ? 31'd0 : 31'h4000_0000 - t;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        u_q[i]    <= hp[i][61:30];
        x2a_q[i]  <= x2_in[i];
        nega_q[i] <= neg_in[i];
        qm_q[i]   <= 65'(u_q[i] * M);
        x2b_q[i]  <= x2a_q[i];
        negb_q[i] <= nega_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= negb_q[7] ? -$signed({1'b0, y_out[7][30:6]}) : $signed({1'b0, y_out[7][30:6]});
    end
  end

  assign cos_o = c_q;

endmodule

### rtl/core/clw_ln.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_ln
// Pipelined natural log of (285 K - T), Q24: normalize, radix-2 divider,
// atanh series.
// ----------------------------------------------------------------------------
module clw_ln import clw_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] temp_i,
  output logic [27:0] ln_o
);

  localparam int unsigned QW = 29;

  logic [15:0] x;
  logic [3:0]  e_d;
  logic [15:0] n;

  logic [16:0]   rem_q [30];
  logic [16:0]   d_q   [30];
  logic [3:0]    ed_q  [30];
  logic [QW-1:0] q_q   [30];

  logic [QW-1:0] z_q;
  logic [27:0]   zz_q;
  logic [3:0]    ez_q;
  logic [57:0]   zsq;

  logic [QW-1:0] p_q  [1:12];
  logic [58:0]   qm_q [1:13];
  logic [29:0]   s_q  [1:13];
  logic [27:0]   zzs_q[1:12];
  logic [3:0]    es_q [1:13];

  logic [29:0] s_fin;
  logic [33:0] l_sum;
  logic [27:0] ln_q;

  always_comb begin
    x   = 16'(T_REF - temp_i);
    e_d = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        e_d = 4'(i);
      end
    end
    n = 16'(x << (4'd15 - e_d));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {1'b0, n[14:0], 1'b0};
      d_q[0]   <= {1'b0, n} + 17'h08000;
      ed_q[0]  <= e_d;
      q_q[0]   <= '0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [17:0] r2;
    logic        ge;
    assign r2 = {rem_q[i], 1'b0};
    assign ge = r2 >= {1'b0, d_q[i]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? 17'(r2 - {1'b0, d_q[i]}) : 17'(r2);
        d_q[i+1]   <= d_q[i];
        ed_q[i+1]  <= ed_q[i];
        q_q[i+1]   <= {q_q[i][QW-2:0], ge};
      end
    end
  end

  assign zsq = 58'(q_q[QW] * q_q[QW]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q  <= q_q[QW];
      zz_q <= zsq[57:30];
      ez_q <= ed_q[QW];
    end
  end

  logic [56:0] p1_prod;
  assign p1_prod = 57'(z_q * zz_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[1]   <= QW'(p1_prod[56:30]);
      qm_q[1]  <= 59'(z_q * 30'(64'd1 << 29));
      s_q[1]   <= '0;
      zzs_q[1] <= zz_q;
      es_q[1]  <= ez_q;
    end
  end

  for (genvar j = 1; j <= 12; j++) begin : g_ser
    localparam int unsigned KA  = 2 * j + 1;
    localparam int unsigned SHA = 29 + $clog2(KA);
    localparam logic [29:0] MA  = 30'(((64'd1 << SHA) + 64'(KA) - 64'd1) / 64'(KA));
    localparam int unsigned KB  = 2 * j - 1;
    localparam int unsigned SHB = 29 + $clog2(KB);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qm_q[j+1] <= 59'(p_q[j] * MA);
        s_q[j+1]  <= s_q[j] + 30'(qm_q[j] >> SHB);
        es_q[j+1] <= es_q[j];
      end
    end

    if (j < 12) begin : g_pow
      logic [56:0] pp;
      assign pp = 57'(p_q[j] * zzs_q[j]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p_q[j+1]   <= QW'(pp[56:30]);
          zzs_q[j+1] <= zzs_q[j];
        end
      end
    end
  end

  assign s_fin = s_q[13] + 30'(qm_q[13] >> (29 + $clog2(25)));
  assign l_sum = 34'(4'(es_q[13] - 4'd7) * LN2_Q30) + 34'({s_fin, 1'b0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ln_q <= l_sum[33:6];
    end
  end

  assign ln_o = ln_q;

endmodule

### rtl/core/clw_ret.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_ret
// One retrieval lane: combines cosine and two logs into CLW, clamps and
// saturates.
// ----------------------------------------------------------------------------
module clw_ret import clw_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [25:0] cos_i,
  input  logic [27:0]        ln_a_i,
  input  logic [27:0]        ln_b_i,
  output logic [15:0]        water_o
);

  logic signed [31:0] c;
  logic signed [31:0] m1_q, m2_q, m3_q, m4_q, m4b_q, m5_q, m5b_q, m5c_q;
  logic signed [31:0] c1_q, c2_q;
  logic signed [31:0] t;
  logic [19:0]        tt;
  logic [15:0]        w_q;

  assign c = 32'(cos_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= smul24(K_1846, c);
      m4_q  <= smul24(K_754, $signed({4'd0, ln_a_i}));
      m5_q  <= smul24(K_2265, $signed({4'd0, ln_b_i}));
      c1_q  <= c;
      m2_q  <= smul24(K_2622 - m1_q, c1_q);
      c2_q  <= c1_q;
      m4b_q <= m4_q;
      m5b_q <= m5_q;
      m3_q  <= smul24(c2_q, (K_8240 - m2_q) + m4b_q);
      m5c_q <= m5b_q;
      w_q   <= (tt > 20'd65535) ? 16'hFFFF : tt[15:0];
    end
  end

  assign t  = m3_q - m5c_q;
  assign tt = t[31] ? 20'd0 : t[31:12];

  assign water_o = w_q;

endmodule

### rtl/core/clw_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_merge
// Merges the two retrieval lanes: mode select, mean, reject mask; holds the
// result register.
// ----------------------------------------------------------------------------
module clw_merge import clw_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [15:0] obs_i,
  input  logic [15:0] sim_i,
  input  clw_side_t   side_i,
  input  clw_cfg_t    cfg_i,
  output clw_res_t    res_o
);

  logic [15:0] ov, sv, wv;
  logic [16:0] sum;
  logic        ok_w;
  logic [3:0]  rej;
  clw_res_t    res_q;

  always_comb begin
    ov  = side_i.ok_obs ? obs_i : 16'd0;
    sv  = side_i.ok_sim ? sim_i : 16'd0;
    sum = {1'b0, ov} + {1'b0, sv};
    case (cfg_i.mode)
      MODE_OBS: begin
        ok_w = side_i.ok_obs;
        wv   = ov;
      end
      MODE_SIM: begin
        ok_w = side_i.ok_sim;
        wv   = sv;
      end
      default: begin
        ok_w = side_i.ok_obs && side_i.ok_sim;
        wv   = ok_w ? sum[16:1] : 16'd0;
      end
    endcase
    for (int j = 0; j < 4; j++) begin
      rej[j] = (j < NUM_CHANNELS) && side_i.apply && (!ok_w || wv > cfg_i.thr[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q.water_value      <= wv;
      res_q.water_absent     <= !ok_w;
      res_q.obs_water        <= ov;
      res_q.obs_water_absent <= !side_i.ok_obs;
      res_q.sim_water        <= sv;
      res_q.sim_water_absent <= !side_i.ok_sim;
      res_q.reject_mask      <= rej;
    end
  end

  assign res_o = res_q;

endmodule
